/* src/ipd_dfr_pkg.sv */
package ipd_dfr_pkg;

    // Framing characters
    localparam logic [7:0] NO_DATA     = 8'hFF;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_UPPERD = 8'h44;

    // Header and trailer lengths
    localparam logic [2:0] SKIP_LEN    = 3'd4;
    localparam logic [2:0] TRAILER_LEN = 3'd6;

    // Configuration
    localparam int         IDLE_BITS      = 10;
    localparam logic [9:0] IDLE_LIMIT_RST = 10'd1000;
    localparam int         LEN_BITS_DEF   = 11;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SKIP    = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_TRAILER = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_CLOSED  = 2'd1,
        EV_TIMEOUT = 2'd2
    } t_event;

    typedef struct packed {
        logic [7:0] data_byte;
        t_event     event_code;
        logic       last_payload;
    } t_result;

endpackage

/* src/ipd_dfr_core.sv */
module ipd_dfr_core #(
    parameter int LEN_BITS = ipd_dfr_pkg::LEN_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_take,
    input  logic [7:0]               i_rx_byte,
    input  logic [9:0]               i_idle_limit,
    output logic                     o_res_push,
    output ipd_dfr_pkg::t_result     o_res
);
    import ipd_dfr_pkg::*;

    t_phase                r_phase,     n_phase;
    logic [2:0]            r_skip_cnt,  n_skip_cnt;
    logic [LEN_BITS-1:0]   r_frame_len, n_frame_len;
    logic [LEN_BITS-1:0]   r_left,      n_left;
    logic [2:0]            r_trl_cnt,   n_trl_cnt;
    logic [IDLE_BITS-1:0]  r_idle_cnt,  n_idle_cnt;

    logic [IDLE_BITS-1:0]  idle_inc;
    logic [2:0]            skip_inc;
    logic [2:0]            trl_inc;
    logic signed [8:0]     digit;
    logic [LEN_BITS-1:0]   len_times_ten;
    logic [LEN_BITS-1:0]   len_next;
    logic                  is_last;

    // Datapath helpers for the length accumulator and counters
    assign idle_inc      = r_idle_cnt + 1'b1;
    assign skip_inc      = r_skip_cnt + 1'b1;
    assign trl_inc       = r_trl_cnt + 1'b1;
    assign digit         = $signed({1'b0, i_rx_byte}) - $signed({1'b0, CHAR_ZERO});
    assign len_times_ten = (r_frame_len << 3) + (r_frame_len << 1);
    assign len_next      = len_times_ten + LEN_BITS'(digit);
    assign is_last       = (r_left <= LEN_BITS'(1));

    // Advance the frame state for one accepted request
    always_comb begin
        n_phase     = r_phase;
        n_skip_cnt  = r_skip_cnt;
        n_frame_len = r_frame_len;
        n_left      = r_left;
        n_trl_cnt   = r_trl_cnt;
        n_idle_cnt  = r_idle_cnt;
        o_res_push  = 1'b0;
        o_res       = '{data_byte: 8'h00, event_code: EV_PAYLOAD, last_payload: 1'b0};

        if (i_take) begin
            if (i_rx_byte == NO_DATA) begin
                // Count idle ticks inside a frame; drop them while hunting
                if (r_phase != PH_HUNT) begin
                    n_idle_cnt = idle_inc;
                    if (idle_inc >= i_idle_limit || idle_inc == '0) begin
                        n_phase          = PH_HUNT;
                        n_skip_cnt       = '0;
                        n_frame_len      = '0;
                        n_left           = '0;
                        n_trl_cnt        = '0;
                        n_idle_cnt       = '0;
                        o_res_push       = 1'b1;
                        o_res.event_code = EV_TIMEOUT;
                    end
                end
            end else begin
                case (r_phase)
                    PH_HUNT: begin
                        if (i_rx_byte == CHAR_PLUS) begin
                            n_phase     = PH_SKIP;
                            n_skip_cnt  = '0;
                            n_frame_len = '0;
                        end
                    end
                    PH_SKIP: begin
                        n_skip_cnt = skip_inc;
                        if (skip_inc >= SKIP_LEN) begin
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (i_rx_byte == CHAR_COLON) begin
                            n_left    = r_frame_len;
                            n_trl_cnt = '0;
                            n_phase   = (r_frame_len == '0) ? PH_TRAILER : PH_PAYLOAD;
                        end else begin
                            n_frame_len = len_next;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_left             = r_left - 1'b1;
                        o_res_push         = 1'b1;
                        o_res.data_byte    = i_rx_byte;
                        o_res.last_payload = is_last;
                        if (is_last) begin
                            n_left    = '0;
                            n_trl_cnt = '0;
                            n_phase   = PH_TRAILER;
                        end
                    end
                    PH_TRAILER: begin
                        if (r_trl_cnt < TRAILER_LEN) begin
                            n_trl_cnt = trl_inc;
                            if (trl_inc == TRAILER_LEN && i_rx_byte == CHAR_UPPERD) begin
                                n_phase          = PH_HUNT;
                                n_skip_cnt       = '0;
                                n_frame_len      = '0;
                                n_left           = '0;
                                n_trl_cnt        = '0;
                                n_idle_cnt       = '0;
                                o_res_push       = 1'b1;
                                o_res.event_code = EV_CLOSED;
                            end
                        end
                    end
                    default: begin
                        n_phase     = PH_HUNT;
                        n_skip_cnt  = '0;
                        n_frame_len = '0;
                        n_left      = '0;
                        n_trl_cnt   = '0;
                        n_idle_cnt  = '0;
                    end
                endcase
            end
        end
    end

    // Hold the frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_skip_cnt  <= '0;
            r_frame_len <= '0;
            r_left      <= '0;
            r_trl_cnt   <= '0;
            r_idle_cnt  <= '0;
        end else begin
            r_phase     <= n_phase;
            r_skip_cnt  <= n_skip_cnt;
            r_frame_len <= n_frame_len;
            r_left      <= n_left;
            r_trl_cnt   <= n_trl_cnt;
            r_idle_cnt  <= n_idle_cnt;
        end
    end

endmodule

/* src/ipd_dfr_outbuf.sv */
module ipd_dfr_outbuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ipd_dfr_pkg::t_result  i_res,
    output logic                  o_can_push,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ipd_dfr_pkg::t_result  o_res
);
    import ipd_dfr_pkg::*;

    logic    r_main_vld, n_main_vld;
    logic    r_skid_vld, n_skid_vld;
    t_result r_main,     n_main;
    t_result r_skid,     n_skid;
    logic    pop;

    assign pop        = r_main_vld & i_ready;
    assign o_can_push = ~r_skid_vld;
    assign o_valid    = r_main_vld;
    assign o_res      = r_main;

    // Refill the output register from the skid stage or a fresh result
    always_comb begin
        n_main_vld = r_main_vld;
        n_skid_vld = r_skid_vld;
        n_main     = r_main;
        n_skid     = r_skid;
        if (r_skid_vld) begin
            if (pop) begin
                n_main     = r_skid;
                n_skid_vld = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_vld || pop) begin
                n_main     = i_res;
                n_main_vld = 1'b1;
            end else begin
                n_skid     = i_res;
                n_skid_vld = 1'b1;
            end
        end else if (pop) begin
            n_main_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_main_vld <= n_main_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

/* src/at_ipd_payload_deframer_unit.sv */
// A result is registered into the output stage from the byte that causes it.
// Throughput: one byte per cycle while o_rx_ready is high; state updates in one pass.
// A two-entry output stage (output register plus skid) keeps input ready while a
// result waits; input stalls only when both entries are full.
// Reset (synchronous, active low): hunting for '+', counters cleared, idle limit 1000,
// output stage empty.
module at_ipd_payload_deframer_unit #(
    parameter int LEN_BITS = ipd_dfr_pkg::LEN_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [7:0] o_data_byte,
    output logic [1:0] o_event_code,
    output logic       o_last_payload,
    input  logic       i_cfg_we,
    input  logic [9:0] i_cfg_wdata
);
    import ipd_dfr_pkg::*;

    logic [IDLE_BITS-1:0] r_idle_limit;
    logic                 take;
    logic                 res_push;
    logic                 can_push;
    t_result              core_res;
    t_result              out_res;

    // Hold the idle limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= IDLE_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_idle_limit <= i_cfg_wdata;
        end
    end

    assign o_rx_ready = can_push;
    assign take       = i_rx_valid & can_push;

    ipd_dfr_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_rx_byte    (i_rx_byte),
        .i_idle_limit (r_idle_limit),
        .o_res_push   (res_push),
        .o_res        (core_res)
    );

    ipd_dfr_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_push),
        .i_res      (core_res),
        .o_can_push (can_push),
        .o_valid    (o_res_valid),
        .i_ready    (i_res_ready),
        .o_res      (out_res)
    );

    assign o_data_byte    = out_res.data_byte;
    assign o_event_code   = out_res.event_code;
    assign o_last_payload = out_res.last_payload;

endmodule
